// File: design/b64sc_pkg.sv
// ----------------------------------------------------------------------------
// b64sc_pkg
// Types, constants and alphabet functions shared by the base64 codec modules.
// ----------------------------------------------------------------------------
package b64sc_pkg;

    localparam int unsigned MaxResults = 4;

    localparam logic [7:0] PadChar = 8'h3D;  // '='

    // Sextet codes beyond the alphabet
    localparam logic [6:0] SextetPad     = 7'd64;
    localparam logic [6:0] SextetInvalid = 7'd65;

    localparam logic CodecDecode = 1'b0;
    localparam logic CodecEncode = 1'b1;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_out;
        logic       bad_symbol;
    } res_t;

    typedef struct packed {
        res_t [MaxResults-1:0] res;
        logic [2:0]            count;
    } burst_t;

    // Six-bit value to standard alphabet character
    function automatic logic [7:0] sextet_char(input logic [5:0] v);
        logic [7:0] v8;
        v8 = {2'b00, v};
        if (v < 6'd26)       return 8'h41 + v8;
        else if (v < 6'd52)  return 8'h61 + (v8 - 8'd26);
        else if (v < 6'd62)  return 8'h30 + (v8 - 8'd52);
        else if (v == 6'd62) return 8'h2B;
        else                 return 8'h2F;
    endfunction

    // Character to six-bit value; SextetPad for '=', SextetInvalid otherwise
    function automatic logic [6:0] char_sextet(input logic [7:0] c);
        if (c >= 8'h41 && c <= 8'h5A)      return 7'(c - 8'h41);
        else if (c >= 8'h61 && c <= 8'h7A) return 7'(c - 8'h61 + 8'd26);
        else if (c >= 8'h30 && c <= 8'h39) return 7'(c - 8'h30 + 8'd52);
        else if (c == 8'h2B)               return 7'd62;
        else if (c == 8'h2F)               return 7'd63;
        else if (c == PadChar)             return SextetPad;
        else                               return SextetInvalid;
    endfunction

endpackage

// File: design/b64sc_step.sv
// ----------------------------------------------------------------------------
// b64sc_step
// Group state, mode register and the per-item encode/decode logic. Produces
// the whole burst of results caused by one item combinationally.
// ----------------------------------------------------------------------------
module b64sc_step
    import b64sc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic       cfg_mode,
    input  logic       item_we,
    input  logic [7:0] data_byte,
    input  logic       last_in,
    output burst_t     burst
);

    logic        mode_reg;
    logic [23:0] gbits_reg, gbits_next;
    logic [1:0]  gcount_reg, gcount_next;
    logic [1:0]  pad_reg, pad_next;

    // encode
    logic [23:0] enc_bits;
    logic [1:0]  enc_n;
    logic [23:0] enc_aligned;

    // decode
    logic [6:0]  sx;
    logic        invalid;
    logic        is_pad;
    logic [5:0]  v6;
    logic [1:0]  dpad;
    logic [23:0] dbits;
    logic [2:0]  dcnt;
    logic        flush;
    logic [2:0]  ddata;
    logic [2:0]  nbytes;
    logic [23:0] dec_aligned;
    logic [2:0]  total;
    res_t [MaxResults-1:0] res;

    always_comb begin
        res         = '0;
        total       = 3'd0;
        gbits_next  = gbits_reg;
        gcount_next = gcount_reg;
        pad_next    = pad_reg;

        enc_bits = {gbits_reg[15:0], data_byte};
        enc_n    = gcount_reg + 2'd1;
        case (enc_n)
            2'd1:    enc_aligned = {data_byte, 16'd0};
            2'd2:    enc_aligned = {gbits_reg[7:0], data_byte, 8'd0};
            default: enc_aligned = enc_bits;
        endcase

        sx      = char_sextet(data_byte);
        invalid = (sx == SextetInvalid);
        is_pad  = (sx == SextetPad);
        v6      = is_pad ? 6'd0 : sx[5:0];
        if (invalid) begin
            dpad  = pad_reg;
            dbits = gbits_reg;
            dcnt  = {1'b0, gcount_reg};
        end else begin
            dpad  = (is_pad && pad_reg != 2'd3) ? pad_reg + 2'd1 : pad_reg;
            dbits = {gbits_reg[17:0], v6};
            dcnt  = {1'b0, gcount_reg} + 3'd1;
        end
        flush  = (dcnt == 3'd4) || last_in;
        ddata  = (dcnt > {1'b0, dpad}) ? dcnt - {1'b0, dpad} : 3'd0;
        nbytes = (ddata >= 3'd2) ? ddata - 3'd1 : 3'd0;
        case (dcnt)
            3'd0:    dec_aligned = 24'd0;
            3'd1:    dec_aligned = {dbits[5:0], 18'd0};
            3'd2:    dec_aligned = {dbits[11:0], 12'd0};
            3'd3:    dec_aligned = {dbits[17:0], 6'd0};
            default: dec_aligned = dbits;
        endcase

        if (mode_reg == CodecEncode) begin
            if (enc_n == 2'd3 || last_in) begin
                for (int i = 0; i < MaxResults; i++) begin
                    res[i].out_byte = (i <= int'(enc_n)) ?
                        sextet_char(enc_aligned[23-6*i -: 6]) : PadChar;
                    res[i].last_out   = last_in && (i == MaxResults - 1);
                    res[i].bad_symbol = 1'b0;
                end
                total       = 3'd4;
                gbits_next  = '0;
                gcount_next = '0;
                pad_next    = '0;
            end else begin
                gbits_next  = enc_bits;
                gcount_next = enc_n;
            end
        end else begin
            if (invalid) begin
                res[0].bad_symbol = 1'b1;
                total = 3'd1;
            end else begin
                gbits_next  = dbits;
                gcount_next = dcnt[1:0];
                pad_next    = dpad;
            end
            if (flush && !(invalid && !last_in)) begin
                for (int i = 0; i < 3; i++) begin
                    if (3'(i) < nbytes) begin
                        if (invalid) res[i+1].out_byte = dec_aligned[23-8*i -: 8];
                        else         res[i].out_byte   = dec_aligned[23-8*i -: 8];
                    end
                end
                total       = total + nbytes;
                gbits_next  = '0;
                gcount_next = '0;
                pad_next    = '0;
            end
            if (last_in) begin
                if (total == 3'd0) begin
                    res[0].last_out = 1'b1;
                    total = 3'd1;
                end else begin
                    for (int i = 0; i < MaxResults; i++) begin
                        if (3'(i) == total - 3'd1) res[i].last_out = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= CodecEncode;
            gbits_reg  <= '0;
            gcount_reg <= '0;
            pad_reg    <= '0;
        end else if (cfg_we) begin
            mode_reg   <= cfg_mode;
            gbits_reg  <= '0;
            gcount_reg <= '0;
            pad_reg    <= '0;
        end else if (item_we) begin
            gbits_reg  <= gbits_next;
            gcount_reg <= gcount_next;
            pad_reg    <= pad_next;
        end
    end

    assign burst.res   = res;
    assign burst.count = total;

endmodule

// File: design/b64sc_burst_buf.sv
// ----------------------------------------------------------------------------
// b64sc_burst_buf
// Result register for up to four results of one item; presents the head
// entry and shifts down as each result is taken.
// ----------------------------------------------------------------------------
module b64sc_burst_buf
    import b64sc_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   load,
    input  burst_t burst,
    output logic   room,
    output logic   m_valid,
    input  logic   m_ready,
    output res_t   head
);

    res_t [MaxResults-1:0] res_reg;
    logic [2:0]            cnt_reg;
    logic                  pop;

    assign m_valid = (cnt_reg != 3'd0);
    assign pop     = m_valid && m_ready;
    // take a new item when empty or once the last pending result leaves this cycle
    assign room    = (cnt_reg == 3'd0) || (cnt_reg == 3'd1 && m_ready);
    assign head    = res_reg[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (load) begin
            cnt_reg <= burst.count;
        end else if (pop) begin
            cnt_reg <= cnt_reg - 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= burst.res;
        end else if (pop) begin
            for (int i = 0; i < MaxResults - 1; i++) res_reg[i] <= res_reg[i+1];
        end
    end

endmodule

// File: design/base64_stream_codec_unit.sv
// ----------------------------------------------------------------------------
// base64_stream_codec_unit
// Streaming base64 codec (standard alphabet) with an encode/decode mode.
// ----------------------------------------------------------------------------
// Each accepted item is processed combinationally, and its results (up to
// four) land in a result register. That register drains one result per cycle
// on the m_ side while m_ready is high. A new item is taken only while the
// register is empty or its last result is being taken in that cycle. Items
// that cause no result still wait for this. An item that causes results
// therefore holds off the next item until its burst has drained. With m_ready
// held high, encoding accepts the three bytes of a group and then waits while
// its four characters drain; decoding accepts four characters and then waits
// while the three bytes drain. The single result port sets the pace of both.
// A cycle with m_ready low stalls the drain. cfg_codec_mode (1 encode, 0
// decode; reset encode) is taken at any time and clears any partial group;
// write it only while the block is idle. The write port is always ready.
// ----------------------------------------------------------------------------
module base64_stream_codec_unit
    import b64sc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_codec_mode,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic       s_last_in,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_last_out,
    output logic       m_bad_symbol
);

    burst_t burst;
    res_t   head;
    logic   accept;
    logic   room;

    assign cfg_ready = 1'b1;
    assign s_ready   = room;
    assign accept    = s_valid && room;

    b64sc_step u_step (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_valid),
        .cfg_mode  (cfg_codec_mode),
        .item_we   (accept),
        .data_byte (s_data_byte),
        .last_in   (s_last_in),
        .burst     (burst)
    );

    b64sc_burst_buf u_buf (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (accept),
        .burst   (burst),
        .room    (room),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .head    (head)
    );

    assign m_out_byte   = head.out_byte;
    assign m_last_out   = head.last_out;
    assign m_bad_symbol = head.bad_symbol;

endmodule

// File: design/b64sc_checker.sv
// ----------------------------------------------------------------------------
// b64sc_checker
// Port-level checks for the base64 codec, bound to the top level.
// ----------------------------------------------------------------------------
module b64sc_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_out_byte,
    input logic       m_last_out,
    input logic       m_bad_symbol
);

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_byte)
            && $stable(m_last_out) && $stable(m_bad_symbol))
        else $error("stalled result changed");

    // an invalid character report carries a zero byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_bad_symbol |-> m_out_byte == 8'd0)
        else $error("bad symbol result with nonzero byte");

    // input is only taken with results pending when the last one leaves now
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready && m_valid |-> m_ready)
        else $error("input ready while results are stalled");

    // leaving reset: empty and ready
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(aresetn) |-> s_ready && !m_valid)
        else $error("not idle after reset");

endmodule

bind base64_stream_codec_unit b64sc_checker u_chk (.*);

// File: tb/sv/base64_stream_codec_unit_tb.sv
// ----------------------------------------------------------------------------
// base64_stream_codec_unit_tb
// Self-checking bench for the streaming base64 codec. A clocked driver feeds
// bytes or characters from a queue, and an internal codec model predicts
// every output. A clocked monitor checks each output against the oldest
// prediction. Mode changes happen only while the block is idle. The run
// covers directed corner messages first and then random messages in both
// modes.
// ----------------------------------------------------------------------------
module base64_stream_codec_unit_tb;
    import b64sc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int QuietLimit = 2000;
    localparam int SettleCycles = 8;
    localparam int MaxPrinted = 60;
    localparam logic [8*64-1:0] Alphabet =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    typedef struct {
        logic [7:0] data;
        logic       fin;
        bit         drain_first;
    } sym_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic       cfg_codec_mode = CodecEncode;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_data_byte = 8'h00;
    logic       s_last_in = 1'b0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_out_byte;
    logic       m_last_out;
    logic       m_bad_symbol;

    sym_t queued_symbols[$];
    res_t due_outputs[$];
    sym_t next_sym;
    res_t want;

    // codec model state
    logic        model_mode = CodecEncode;
    logic [23:0] grp_bits = '0;
    logic [1:0]  grp_cnt = '0;
    logic [1:0]  pad_cnt = '0;

    int  err_count = 0;
    int  quiet_cycles = 0;
    bit  steady = 1'b0;

    base64_stream_codec_unit u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_codec_mode (cfg_codec_mode),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_byte    (s_data_byte),
        .s_last_in      (s_last_in),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_byte     (m_out_byte),
        .m_last_out     (m_last_out),
        .m_bad_symbol   (m_bad_symbol)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic logic [7:0] alpha_at(input logic [5:0] idx);
        return Alphabet[8*(63 - int'(idx)) +: 8];
    endfunction

    function automatic bit take_break();
        return !steady && ($urandom_range(0, 99) < 17);
    endfunction

    task automatic flag_error(input string what);
        if (err_count < MaxPrinted)
            $display("MISMATCH @%0t: %s", $realtime, what);
        err_count++;
    endtask

    function automatic void clear_group();
        grp_bits = '0;
        grp_cnt = '0;
        pad_cnt = '0;
    endfunction

    // Advance the codec model by one accepted item, append its outputs
    function automatic void codec_step(input logic [7:0] sym, input logic fin);
        res_t        outs [4];
        int          k, n, cnt, nbytes, data_chars, sx, i;
        logic [23:0] aligned;
        k = 0;
        if (model_mode == CodecEncode) begin
            grp_bits = {grp_bits[15:0], sym};
            n = grp_cnt + 1;
            if (n == 3 || fin) begin
                aligned = grp_bits << (8 * (3 - n));
                for (i = 0; i < 4; i++) begin
                    outs[i].out_byte = (i <= n) ? alpha_at(6'(aligned >> (18 - 6*i)))
                                                : PadChar;
                    outs[i].last_out = fin && (i == 3);
                    outs[i].bad_symbol = 1'b0;
                end
                k = 4;
                clear_group();
            end else begin
                grp_cnt = 2'(n);
            end
        end else begin
            sx = SextetInvalid;
            for (i = 0; i < 64; i++)
                if (alpha_at(6'(i)) == sym) sx = i;
            if (sym == PadChar) sx = SextetPad;
            cnt = -1;  // no flush in this step
            if (sx == SextetInvalid) begin
                outs[0] = '{8'h00, 1'b0, 1'b1};
                k = 1;
                if (fin) cnt = grp_cnt;
            end else begin
                if (sx == SextetPad) begin
                    sx = 0;
                    if (pad_cnt != 2'd3) pad_cnt++;
                end
                grp_bits = {grp_bits[17:0], 6'(sx)};
                n = grp_cnt + 1;
                grp_cnt = 2'(n);
                if (n == 4 || fin) cnt = n;
            end
            if (cnt >= 0) begin
                data_chars = (cnt > pad_cnt) ? cnt - pad_cnt : 0;
                nbytes = (data_chars >= 2) ? data_chars - 1 : 0;
                aligned = (cnt == 0) ? 24'h0 : grp_bits << (6 * (4 - cnt));
                for (i = 0; i < nbytes; i++) begin
                    outs[k] = '{8'(aligned >> (16 - 8*i)), 1'b0, 1'b0};
                    k++;
                end
                clear_group();
                if (fin) begin
                    // mark end of message even when nothing was decoded
                    if (k == 0) begin
                        outs[0] = '{8'h00, 1'b1, 1'b0};
                        k = 1;
                    end else begin
                        outs[k-1].last_out = 1'b1;
                    end
                end
            end
        end
        for (i = 0; i < k; i++)
            due_outputs.push_back(outs[i]);
    endfunction

    // Driver: present queued items, predict on acceptance
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                codec_step(s_data_byte, s_last_in);
            if (!s_valid || s_ready) begin
                if (queued_symbols.size() != 0 && !take_break() &&
                        !(queued_symbols[0].drain_first && due_outputs.size() != 0)) begin
                    next_sym = queued_symbols.pop_front();
                    s_data_byte <= next_sym.data;
                    s_last_in <= next_sym.fin;
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each accepted output against the oldest prediction
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (due_outputs.size() == 0) begin
                    flag_error($sformatf("unexpected output %02h last %0b bad %0b",
                                         m_out_byte, m_last_out, m_bad_symbol));
                end else begin
                    want = due_outputs.pop_front();
                    if (m_out_byte !== want.out_byte)
                        flag_error($sformatf("out_byte %02h, want %02h",
                                             m_out_byte, want.out_byte));
                    if (m_last_out !== want.last_out)
                        flag_error($sformatf("last_out %0b, want %0b",
                                             m_last_out, want.last_out));
                    if (m_bad_symbol !== want.bad_symbol)
                        flag_error($sformatf("bad_symbol %0b, want %0b",
                                             m_bad_symbol, want.bad_symbol));
                end
            end
            m_ready <= !take_break();
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QuietLimit) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic queue_sym(input logic [7:0] data, input logic fin, input bit drain);
        sym_t s;
        s.data = data;
        s.fin = fin;
        s.drain_first = drain;
        queued_symbols.push_back(s);
    endtask

    task automatic queue_text(input string txt, input logic fin);
        int i;
        for (i = 0; i < txt.len(); i++)
            queue_sym(txt[i], fin && (i == txt.len() - 1), 1'b0);
    endtask

    task automatic queue_encode_msg(input int len);
        int j;
        for (j = 0; j < len; j++)
            queue_sym(8'($urandom_range(0, 255)), j == len - 1, 1'b0);
    endtask

    // Mostly well-formed groups; noisy messages get cut groups and stray bytes
    task automatic queue_decode_msg(input int n_groups, input bit noisy, input bit drain);
        int         g, j, n_pad, n_chars;
        logic [7:0] c;
        for (g = 0; g < n_groups; g++) begin
            n_pad = (g == n_groups - 1) ? $urandom_range(0, 2) : 0;
            n_chars = 4;
            if (noisy && $urandom_range(0, 3) == 0) n_chars = $urandom_range(1, 4);
            for (j = 0; j < n_chars; j++) begin
                if (j >= 4 - n_pad) c = PadChar;
                else c = alpha_at(6'($urandom_range(0, 63)));
                if (noisy && $urandom_range(0, 5) == 0) c = 8'($urandom_range(0, 255));
                queue_sym(c, (g == n_groups - 1) && (j == n_chars - 1),
                          drain && g == 0 && j == 0);
            end
        end
    endtask

    task automatic wait_idle();
        while (queued_symbols.size() != 0 || s_valid || due_outputs.size() != 0)
            @(posedge aclk);
        // items with no output may still be in flight
        repeat (SettleCycles) @(posedge aclk);
    endtask

    task automatic write_mode(input logic mode);
        cfg_codec_mode <= mode;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        model_mode = mode;
        clear_group();
    endtask

    initial begin
        int i;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // encode from reset: full group, one-byte and two-byte tails
        queue_sym(8'h00, 1'b0, 1'b0);
        queue_sym(8'hFF, 1'b0, 1'b0);
        queue_sym(8'h80, 1'b1, 1'b0);
        queue_sym(8'hFF, 1'b1, 1'b0);
        queue_sym(8'h7F, 1'b0, 1'b0);
        queue_sym(8'h01, 1'b1, 1'b0);
        wait_idle();

        // decode: alphabet edges, invalid chars, invalid on last, lone tail,
        // data after padding
        write_mode(CodecDecode);
        queue_text("AZaz09+/", 1'b0);
        queue_sym("Q", 1'b0, 1'b0);
        queue_sym(8'h00, 1'b0, 1'b0);
        queue_text("Q=", 1'b0);
        queue_sym(8'hFF, 1'b1, 1'b0);
        queue_text("Q", 1'b1);
        queue_text("A=B", 1'b1);
        wait_idle();

        // random encode without any idling
        write_mode(CodecEncode);
        steady = 1'b1;
        for (i = 0; i < 6; i++) queue_encode_msg($urandom_range(1, 7));
        wait_idle();
        steady = 1'b0;

        // well-formed decode, some messages held off until earlier outputs drain
        write_mode(CodecDecode);
        for (i = 0; i < 6; i++)
            queue_decode_msg($urandom_range(1, 3), 1'b0,
                             i == 0 || $urandom_range(0, 2) == 0);
        wait_idle();

        write_mode(CodecEncode);
        for (i = 0; i < 4; i++) queue_encode_msg($urandom_range(1, 7));
        wait_idle();

        write_mode(CodecDecode);
        for (i = 0; i < 5; i++) queue_decode_msg($urandom_range(1, 2), 1'b1, 1'b0);
        wait_idle();

        repeat (10) @(posedge aclk);
        if (err_count == 0 && due_outputs.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
